FILE: rtl/sdes_pkg.sv
// ----------------------------------------------------------------------------
// sdes_pkg
// Shared types, register and mode codes, S-boxes and round helpers for the
// 12-bit simplified DES block cipher.
// ----------------------------------------------------------------------------
package sdes_pkg;

	localparam int BLOCK_W = 12;
	localparam int HALF_W  = 6;
	localparam int KEY_W   = 9;
	localparam int RKEY_W  = 8;
	localparam int ROUND_W = 6;
	localparam int MODE_W  = 2;
	localparam int CIDX_W  = 2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_KEY    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_ROUNDS = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_MODE   = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_IV     = 2'd3;

	// operating modes
	localparam logic [MODE_W-1:0] MODE_ECB_ENC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ECB_DEC = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CBC_ENC = 2'd2;

	// register reset values
	localparam logic [KEY_W-1:0]   KEY_RST    = 9'd0;
	localparam logic [ROUND_W-1:0] ROUNDS_RST = 6'd4;
	localparam logic [MODE_W-1:0]  MODE_RST   = MODE_ECB_ENC;
	localparam logic [BLOCK_W-1:0] IV_RST     = 12'hE38;

	// s-boxes, indexed by {row bit, three column bits}
	localparam logic [2:0] SBOX_ONE [0:15] = '{
		3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
		3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3
	};
	localparam logic [2:0] SBOX_TWO [0:15] = '{
		3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
		3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4
	};

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	// key schedule control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
		logic dec;
	} key_ctl_t;

	// exchange left and right halves
	function automatic logic [BLOCK_W-1:0] swap_halves(input logic [BLOCK_W-1:0] blk);
		swap_halves = {blk[HALF_W-1:0], blk[BLOCK_W-1:HALF_W]};
	endfunction

endpackage

FILE: rtl/simplified_des_block_cipher_top.sv
// ----------------------------------------------------------------------------
// simplified_des_block_cipher_top
// 12-bit simplified DES engine: ECB encrypt, ECB decrypt and CBC encrypt.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key,
//   round count, mode and IV; cfg_ready is always high. Write only while
//   the engine is idle.
//   in channel (in_valid/in_ready) takes data_block and chain_start; in
//   CBC mode chain_start selects the IV instead of the last ciphertext.
//   out channel (out_valid/out_ready) delivers result_block from an
//   output register.
// Timing: one shared round unit runs one Feistel round per cycle; a new
//   word is taken only after the last block's result has been written
//   into the output register.
// Reset: registers return to their defaults and the CBC chain clears.
// Stall: a finished word waits in the output register; a following block
//   runs meanwhile and, if its result is ready first, holds until the
//   output register frees up.
// ----------------------------------------------------------------------------
module simplified_des_block_cipher_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sdes_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [sdes_pkg::BLOCK_W-1:0]  cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sdes_pkg::BLOCK_W-1:0]  data_block,
	input  logic                          chain_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdes_pkg::BLOCK_W-1:0]  result_block
);

	logic [sdes_pkg::KEY_W-1:0]   cipher_key_q;
	logic [sdes_pkg::ROUND_W-1:0] round_count_q;
	logic [sdes_pkg::MODE_W-1:0]  op_mode_q;
	logic [sdes_pkg::BLOCK_W-1:0] init_vector_q;
	logic [sdes_pkg::BLOCK_W-1:0] chain_q;

	sdes_pkg::state_t             state_q;
	logic [sdes_pkg::ROUND_W-1:0] rem_q;
	logic                         dec_q;
	logic                         cbc_q;
	logic [sdes_pkg::BLOCK_W-1:0] blk_q;
	logic                         out_valid_q;
	logic [sdes_pkg::BLOCK_W-1:0] result_q;

	logic                         in_acc;
	logic                         out_free;
	logic                         last_round;
	logic                         wr_en;
	logic [sdes_pkg::BLOCK_W-1:0] wr_data;
	logic [sdes_pkg::BLOCK_W-1:0] load_blk;
	logic [sdes_pkg::BLOCK_W-1:0] rnd_out;
	logic [sdes_pkg::RKEY_W-1:0]  round_key;
	sdes_pkg::key_ctl_t           key_ctl;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (state_q == sdes_pkg::ST_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign out_valid    = out_valid_q;
	assign result_block = result_q;
	assign out_free     = !out_valid_q || out_ready;
	assign last_round   = (state_q == sdes_pkg::ST_RUN) && (rem_q == 6'd1);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_key_q  <= sdes_pkg::KEY_RST;
			round_count_q <= sdes_pkg::ROUNDS_RST;
			op_mode_q     <= sdes_pkg::MODE_RST;
			init_vector_q <= sdes_pkg::IV_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sdes_pkg::CFG_KEY:    cipher_key_q  <= cfg_data[sdes_pkg::KEY_W-1:0];
				sdes_pkg::CFG_ROUNDS: round_count_q <= cfg_data[sdes_pkg::ROUND_W-1:0];
				sdes_pkg::CFG_MODE:   op_mode_q     <= cfg_data[sdes_pkg::MODE_W-1:0];
				sdes_pkg::CFG_IV:     init_vector_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input word prepared for the first round
	always_comb begin
		logic [sdes_pkg::BLOCK_W-1:0] mix;
		mix = chain_start ? init_vector_q : chain_q;
		priority if (op_mode_q == sdes_pkg::MODE_ECB_DEC)
			load_blk = sdes_pkg::swap_halves(data_block);
		else if (op_mode_q == sdes_pkg::MODE_CBC_ENC)
			load_blk = data_block ^ mix;
		else
			load_blk = data_block;
	end

	// shared round unit and key schedule
	assign key_ctl.load = in_acc;
	assign key_ctl.step = (state_q == sdes_pkg::ST_RUN);
	assign key_ctl.dec  = (op_mode_q == sdes_pkg::MODE_ECB_DEC);

	sdes_key_sched u_key (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (key_ctl),
		.cipher_key (cipher_key_q),
		.round_count(round_count_q),
		.round_key  (round_key)
	);

	sdes_round u_round (
		.blk      (blk_q),
		.round_key(round_key),
		.blk_next (rnd_out)
	);

	// result write into the output register
	always_comb begin
		logic [sdes_pkg::BLOCK_W-1:0] fin_blk;
		fin_blk = last_round ? rnd_out : blk_q;
		wr_data = dec_q ? sdes_pkg::swap_halves(fin_blk) : fin_blk;
		wr_en   = out_free && (last_round || (state_q == sdes_pkg::ST_FIN));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdes_pkg::ST_IDLE;
			rem_q   <= '0;
			dec_q   <= 1'b0;
			cbc_q   <= 1'b0;
		end else begin
			unique case (state_q)
				sdes_pkg::ST_IDLE: begin
					if (in_acc) begin
						rem_q   <= round_count_q;
						dec_q   <= (op_mode_q == sdes_pkg::MODE_ECB_DEC);
						cbc_q   <= (op_mode_q == sdes_pkg::MODE_CBC_ENC);
						state_q <= (round_count_q == '0) ? sdes_pkg::ST_FIN : sdes_pkg::ST_RUN;
					end
				end
				sdes_pkg::ST_RUN: begin
					rem_q <= rem_q - 1'b1;
					if (last_round)
						state_q <= out_free ? sdes_pkg::ST_IDLE : sdes_pkg::ST_FIN;
				end
				sdes_pkg::ST_FIN: begin
					if (out_free)
						state_q <= sdes_pkg::ST_IDLE;
				end
				default: state_q <= sdes_pkg::ST_IDLE;
			endcase
		end
	end

	// working block
	always_ff @(posedge clk) begin
		if (in_acc)
			blk_q <= load_blk;
		else if (state_q == sdes_pkg::ST_RUN)
			blk_q <= rnd_out;
	end

	// output valid and cbc chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			chain_q     <= '0;
		end else begin
			if (wr_en)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (wr_en && cbc_q)
				chain_q <= wr_data;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (wr_en)
			result_q <= wr_data;
	end

`ifndef ASSERT_OFF
	// a running block always has rounds left
	a_run_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdes_pkg::ST_RUN) |-> (rem_q != '0))
		else $error("round sequencer running with no rounds left");

	// after its last round, a block only enters the hold state while the output register is full
	a_fin_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdes_pkg::ST_FIN) && (rem_q != '0) |-> out_valid_q)
		else $error("finished block held while output register is empty");

	// an accepted block with rounds starts the round loop
	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (round_count_q != '0) |=> (state_q == sdes_pkg::ST_RUN))
		else $error("accepted block did not start its rounds");

	// the output register is never overwritten while a word waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!out_valid_q || out_ready))
		else $error("output word overwritten before it was taken");
`endif

endmodule

FILE: rtl/sdes_round.sv
// ----------------------------------------------------------------------------
// sdes_round
// One Feistel round: expansion, key mix, two 4-to-3 s-boxes and the half
// swap. Reused by the sequencer for every round of a block.
// ----------------------------------------------------------------------------
module sdes_round (
	input  logic [sdes_pkg::BLOCK_W-1:0] blk,
	input  logic [sdes_pkg::RKEY_W-1:0]  round_key,
	output logic [sdes_pkg::BLOCK_W-1:0] blk_next
);

	logic [sdes_pkg::HALF_W-1:0] left_h;
	logic [sdes_pkg::HALF_W-1:0] right_h;
	logic [sdes_pkg::RKEY_W-1:0] expanded;
	logic [sdes_pkg::RKEY_W-1:0] mixed;
	logic [2:0]                  s1_out;
	logic [2:0]                  s2_out;

	assign left_h  = blk[sdes_pkg::BLOCK_W-1:sdes_pkg::HALF_W];
	assign right_h = blk[sdes_pkg::HALF_W-1:0];

	// expand right half to bits 1,2,4,3,4,3,5,6 (bit 1 is the msb)
	assign expanded = {right_h[5], right_h[4], right_h[2], right_h[3],
		right_h[2], right_h[3], right_h[1], right_h[0]};
	assign mixed = expanded ^ round_key;

	// s-box lookups
	assign s1_out = sdes_pkg::SBOX_ONE[mixed[7:4]];
	assign s2_out = sdes_pkg::SBOX_TWO[mixed[3:0]];

	// new left is old right, new right is left xor f
	assign blk_next = {right_h, left_h ^ {s1_out, s2_out}};

endmodule

FILE: rtl/sdes_key_sched.sv
// ----------------------------------------------------------------------------
// sdes_key_sched
// Rotating key register. Loads the key at the first round's rotation and
// turns it one place per round, left for encryption, right for decryption.
// ----------------------------------------------------------------------------
module sdes_key_sched (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sdes_pkg::key_ctl_t           ctl,
	input  logic [sdes_pkg::KEY_W-1:0]   cipher_key,
	input  logic [sdes_pkg::ROUND_W-1:0] round_count,
	output logic [sdes_pkg::RKEY_W-1:0]  round_key
);

	logic [sdes_pkg::KEY_W-1:0]   rot_q;
	logic                         dec_q;
	logic [sdes_pkg::ROUND_W-1:0] last_idx;
	logic [3:0]                   start_shift;
	logic [2*sdes_pkg::KEY_W-1:0] rot_wide;

	// decryption starts at round n: rotation (n - 1) mod 9
	always_comb begin
		logic [sdes_pkg::ROUND_W-1:0] v;
		last_idx = (round_count == '0) ? '0 : round_count - 1'b1;
		v = last_idx;
		for (int i = 0; i < 6; i++) begin
			if (v >= sdes_pkg::ROUND_W'(sdes_pkg::KEY_W))
				v = v - sdes_pkg::ROUND_W'(sdes_pkg::KEY_W);
		end
		start_shift = v[3:0];
	end

	assign rot_wide = {cipher_key, cipher_key} << start_shift;

	// key rotation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
			dec_q <= 1'b0;
		end else if (ctl.load) begin
			dec_q <= ctl.dec;
			rot_q <= ctl.dec ? rot_wide[2*sdes_pkg::KEY_W-1:sdes_pkg::KEY_W] : cipher_key;
		end else if (ctl.step) begin
			rot_q <= dec_q ? {rot_q[0], rot_q[sdes_pkg::KEY_W-1:1]}
				: {rot_q[sdes_pkg::KEY_W-2:0], rot_q[sdes_pkg::KEY_W-1]};
		end
	end

	assign round_key = rot_q[sdes_pkg::KEY_W-1:1];

endmodule

FILE: test/simplified_des_block_cipher_top_tb.sv
// ----------------------------------------------------------------------------
// simplified_des_block_cipher_top_tb
// Self-checking bench for the 12-bit simplified DES engine. A scoreboard
// works out every cipher block from the accepted input word and its own copy
// of the key, round count, mode, IV and CBC chain, and compares it with each
// word taken from the out channel. Directed blocks cover the key, round and
// mode extremes, zero rounds, the spare mode and CBC chaining without a start
// word. Random phases follow with new settings, CBC messages (mostly well
// formed, some broken) and random stalls on the in and out channels.
// ----------------------------------------------------------------------------
module simplified_des_block_cipher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// mode code with no name in the package, runs as ecb encrypt
	localparam bit [sdes_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
	localparam bit [3:0]                  WRITE_ALL  = 4'hF;

	// cipher model with its own register copy and chain state
	class sdes_scoreboard;
		bit [sdes_pkg::KEY_W-1:0]   key;
		bit [sdes_pkg::ROUND_W-1:0] rounds;
		bit [sdes_pkg::MODE_W-1:0]  mode;
		bit [sdes_pkg::BLOCK_W-1:0] iv;
		bit [sdes_pkg::BLOCK_W-1:0] chain;
		bit [sdes_pkg::BLOCK_W-1:0] awaited_blocks[$];
		int               mismatches;
		int               checked;
		int               mode_blocks[4];
		bit [2:0]         s1_tbl[16] = '{3'd5, 3'd2, 3'd1, 3'd6, 3'd3, 3'd4, 3'd7, 3'd0,
		                                 3'd1, 3'd4, 3'd6, 3'd2, 3'd0, 3'd7, 3'd5, 3'd3};
		bit [2:0]         s2_tbl[16] = '{3'd4, 3'd0, 3'd6, 3'd5, 3'd7, 3'd1, 3'd3, 3'd2,
		                                 3'd5, 3'd3, 3'd0, 3'd7, 3'd6, 3'd2, 3'd1, 3'd4};

		function new();
			key        = sdes_pkg::KEY_RST;
			rounds     = sdes_pkg::ROUNDS_RST;
			mode       = sdes_pkg::MODE_RST;
			iv         = sdes_pkg::IV_RST;
			chain      = '0;
			mismatches = 0;
			checked    = 0;
			foreach (mode_blocks[m]) mode_blocks[m] = 0;
		endfunction

		function void write_reg(bit [sdes_pkg::CIDX_W-1:0] idx,
				bit [sdes_pkg::BLOCK_W-1:0] val);
			case (idx)
				sdes_pkg::CFG_KEY:    key    = val[sdes_pkg::KEY_W-1:0];
				sdes_pkg::CFG_ROUNDS: rounds = val[sdes_pkg::ROUND_W-1:0];
				sdes_pkg::CFG_MODE:   mode   = val[sdes_pkg::MODE_W-1:0];
				sdes_pkg::CFG_IV:     iv     = val;
				default:    ;
			endcase
		endfunction

		// key rotated left by (round - 1) mod 9, upper eight bits kept
		function bit [sdes_pkg::RKEY_W-1:0] round_key(int idx);
			int              shift;
			bit [2*sdes_pkg::KEY_W-1:0] twice;
			shift = (idx - 1) % sdes_pkg::KEY_W;
			twice = {key, key} << shift;
			return twice[2*sdes_pkg::KEY_W-1:sdes_pkg::KEY_W+1];
		endfunction

		// expansion 1,2,4,3,4,3,5,6 then the two s-boxes
		function bit [sdes_pkg::HALF_W-1:0] mix_half(bit [sdes_pkg::HALF_W-1:0] r,
				bit [sdes_pkg::RKEY_W-1:0] rk);
			bit [sdes_pkg::RKEY_W-1:0] x;
			x = {r[5], r[4], r[2], r[3], r[2], r[3], r[1], r[0]} ^ rk;
			return {s1_tbl[x[7:4]], s2_tbl[x[3:0]]};
		endfunction

		function bit [sdes_pkg::BLOCK_W-1:0] one_round(bit [sdes_pkg::BLOCK_W-1:0] blk, int idx);
			return {blk[sdes_pkg::HALF_W-1:0],
			        blk[sdes_pkg::BLOCK_W-1:sdes_pkg::HALF_W]
			        ^ mix_half(blk[sdes_pkg::HALF_W-1:0], round_key(idx))};
		endfunction

		function bit [sdes_pkg::BLOCK_W-1:0] encipher(bit [sdes_pkg::BLOCK_W-1:0] blk);
			for (int i = 1; i <= rounds; i++) blk = one_round(blk, i);
			return blk;
		endfunction

		// swap, keys in reverse order, swap back
		function bit [sdes_pkg::BLOCK_W-1:0] decipher(bit [sdes_pkg::BLOCK_W-1:0] blk);
			blk = {blk[sdes_pkg::HALF_W-1:0], blk[sdes_pkg::BLOCK_W-1:sdes_pkg::HALF_W]};
			for (int i = rounds; i >= 1; i--) blk = one_round(blk, i);
			return {blk[sdes_pkg::HALF_W-1:0], blk[sdes_pkg::BLOCK_W-1:sdes_pkg::HALF_W]};
		endfunction

		// accepted input word: work out its result block
		function void note_block(bit [sdes_pkg::BLOCK_W-1:0] data, bit start);
			bit [sdes_pkg::BLOCK_W-1:0] res;
			mode_blocks[mode]++;
			if (mode == sdes_pkg::MODE_ECB_DEC) begin
				res = decipher(data);
			end else if (mode == sdes_pkg::MODE_CBC_ENC) begin
				res   = encipher(data ^ (start ? iv : chain));
				chain = res;
			end else begin
				res = encipher(data);
			end
			awaited_blocks.push_back(res);
		endfunction

		// accepted result word against the oldest awaited block
		function void check_result(logic [sdes_pkg::BLOCK_W-1:0] got);
			bit [sdes_pkg::BLOCK_W-1:0] want;
			checked++;
			if (awaited_blocks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word %0d: %03h arrived with nothing awaited", checked, got);
				return;
			end
			want = awaited_blocks.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result word %0d: expected %03h, got %03h", checked, want, got);
			end
		endfunction

		function int outstanding();
			return awaited_blocks.size();
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [sdes_pkg::CIDX_W-1:0]   cfg_index;
	logic [sdes_pkg::BLOCK_W-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [sdes_pkg::BLOCK_W-1:0]  data_block;
	logic                          chain_start;
	logic                          out_valid;
	logic                          out_ready;
	logic [sdes_pkg::BLOCK_W-1:0]  result_block;

	sdes_scoreboard sb = new();
	bit             tx_steady;
	int             blocks_sent;
	int             settings_used;

	simplified_des_block_cipher_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_block   (data_block),
		.chain_start  (chain_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_block (result_block)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// result side: random stalls, with stretches of steady ready
	initial begin
		int gap;
		int taken;
		bit steady;
		out_ready = 1'b0;
		taken     = 0;
		steady    = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (taken % 40 == 0) steady = ($urandom_range(0, 3) == 0);
			gap = steady ? 0 : $urandom_range(0, 11);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(result_block);
			taken++;
		end
	end

	// one input word, after a random gap unless the phase runs steady
	task automatic send_block(input bit [sdes_pkg::BLOCK_W-1:0] data, input bit start);
		int gap;
		@(negedge clk);
		gap = tx_steady ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_block  <= data;
		chain_start <= start;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_block(data, start);
		blocks_sent++;
	endtask

	// hold the in channel until every awaited block has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input bit [sdes_pkg::CIDX_W-1:0] idx,
			input bit [sdes_pkg::BLOCK_W-1:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	// new register settings once the engine is idle; which selects registers
	task automatic apply_settings(input bit [sdes_pkg::KEY_W-1:0] key,
			input bit [sdes_pkg::ROUND_W-1:0] rounds,
			input bit [sdes_pkg::MODE_W-1:0] mode, input bit [sdes_pkg::BLOCK_W-1:0] iv,
			input bit [3:0] which);
		wait_drained();
		if (which[sdes_pkg::CFG_KEY])
			write_reg(sdes_pkg::CFG_KEY, sdes_pkg::BLOCK_W'(key));
		if (which[sdes_pkg::CFG_ROUNDS])
			write_reg(sdes_pkg::CFG_ROUNDS, sdes_pkg::BLOCK_W'(rounds));
		if (which[sdes_pkg::CFG_MODE])
			write_reg(sdes_pkg::CFG_MODE, sdes_pkg::BLOCK_W'(mode));
		if (which[sdes_pkg::CFG_IV])
			write_reg(sdes_pkg::CFG_IV, iv);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic bit [sdes_pkg::BLOCK_W-1:0] pick_block();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return sdes_pkg::BLOCK_W'($urandom_range(0, 4095));
		endcase
	endfunction

	// stimulus
	initial begin
		bit [sdes_pkg::KEY_W-1:0]   key;
		bit [sdes_pkg::ROUND_W-1:0] rounds;
		bit [sdes_pkg::MODE_W-1:0]  mode;
		bit [sdes_pkg::BLOCK_W-1:0] iv;
		int               random_blocks;
		int               phase_len;
		int               sent;
		int               msg_len;
		bit               broken;
		bit               start;
		bit               first;

		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = sdes_pkg::CFG_KEY;
		cfg_data      = '0;
		in_valid      = 1'b0;
		data_block    = '0;
		chain_start   = 1'b0;
		tx_steady     = 1'b0;
		blocks_sent   = 0;
		settings_used = 1;
		random_blocks = 0;
		first         = 1'b1;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: key 0, four rounds, ecb encrypt, chain flag ignored
		send_block(12'h000, 1'b0);
		send_block(12'hFFF, 1'b1);
		send_block(12'hE38, 1'b0);
		send_block(12'h1C7, 1'b1);

		// full key, most rounds, ecb decrypt
		apply_settings(9'h1FF, 6'd63, sdes_pkg::MODE_ECB_DEC, 12'h000, WRITE_ALL);
		send_block(12'h000, 1'b0);
		send_block(12'hFFF, 1'b0);
		send_block(12'hA5A, 1'b1);
		send_block(12'h5A5, 1'b0);

		// zero rounds pass blocks through in both directions
		apply_settings(9'h0B3, 6'd0, sdes_pkg::MODE_ECB_ENC, 12'h000, 4'b0111);
		send_block(12'h123, 1'b0);
		send_block(12'hEDC, 1'b1);
		apply_settings(9'h0B3, 6'd0, sdes_pkg::MODE_ECB_DEC, 12'h000,
			4'(1 << sdes_pkg::CFG_MODE));
		send_block(12'h123, 1'b0);
		send_block(12'hEDC, 1'b0);

		// spare mode code behaves as ecb encrypt
		apply_settings(9'h100, 6'd9, MODE_SPARE, 12'h000, 4'b0111);
		send_block(12'h800, 1'b1);
		send_block(12'h001, 1'b0);

		// cbc from the cleared chain, then a message with the iv, keys past nine
		apply_settings(9'h001, 6'd10, sdes_pkg::MODE_CBC_ENC, 12'hFFF, WRITE_ALL);
		send_block(12'h000, 1'b0);
		send_block(12'h3C3, 1'b0);
		send_block(12'h555, 1'b1);
		wait_drained();
		send_block(12'hAAA, 1'b0);
		send_block(12'h000, 1'b0);
		send_block(12'hFFF, 1'b0);

		// random phases
		while (random_blocks < 420) begin
			case ($urandom_range(0, 5))
				0:       key = '0;
				1:       key = '1;
				default: key = sdes_pkg::KEY_W'($urandom_range(0, 511));
			endcase
			case ($urandom_range(0, 9))
				0:       rounds = 6'd0;
				1:       rounds = 6'd63;
				2:       rounds = sdes_pkg::ROUND_W'($urandom_range(10, 62));
				default: rounds = sdes_pkg::ROUND_W'($urandom_range(1, 9));
			endcase
			case ($urandom_range(0, 7))
				0:       mode = sdes_pkg::MODE_ECB_ENC;
				1:       mode = MODE_SPARE;
				2, 3:    mode = sdes_pkg::MODE_ECB_DEC;
				default: mode = sdes_pkg::MODE_CBC_ENC;
			endcase
			case ($urandom_range(0, 7))
				0:       iv = '0;
				1:       iv = '1;
				default: iv = sdes_pkg::BLOCK_W'($urandom_range(0, 4095));
			endcase
			apply_settings(key, rounds, mode, iv,
				first ? WRITE_ALL : 4'($urandom_range(1, 15)));
			first     = 1'b0;
			tx_steady = ($urandom_range(0, 3) == 0);
			phase_len = $urandom_range(20, 40);
			sent      = 0;
			while (sent < phase_len) begin
				// pause until the engine has emptied out
				if ($urandom_range(0, 29) == 0) wait_drained();
				if (sb.mode == sdes_pkg::MODE_CBC_ENC) begin
					// cbc message: start word then chained words, a few broken
					msg_len = $urandom_range(1, 8);
					broken  = ($urandom_range(0, 7) == 0);
					for (int j = 0; j < msg_len; j++) begin
						start = broken ? 1'($urandom_range(0, 1)) : (j == 0);
						send_block(pick_block(), start);
					end
					sent += msg_len;
				end else begin
					send_block(pick_block(), 1'($urandom_range(0, 1)));
					sent++;
				end
			end
			random_blocks += sent;
		end

		// drain and watch for stray words
		wait_drained();
		repeat (80) @(posedge clk);
		$display("sent %0d blocks under %0d register settings, %0d result words checked",
			blocks_sent, settings_used, sb.checked);
		$display("per mode: ecb encrypt %0d, ecb decrypt %0d, cbc encrypt %0d, spare %0d",
			sb.mode_blocks[sdes_pkg::MODE_ECB_ENC], sb.mode_blocks[sdes_pkg::MODE_ECB_DEC],
			sb.mode_blocks[sdes_pkg::MODE_CBC_ENC], sb.mode_blocks[MODE_SPARE]);
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d bad result words, %0d blocks never returned",
				sb.mismatches, sb.outstanding());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
